/* sv/srs_pkg.sv */
package srs_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // shared arithmetic widths
  localparam int WIDE_W = 112;  // product / dividend register
  localparam int MAG_W  = 34;   // |x*2^F - mean|
  localparam int REM_W  = 25;   // divider remainder, holds count or digitisation
  localparam int SQV_W  = 64;
  localparam int SQR_W  = 34;
  localparam int ROOT_W = 32;

  localparam int REP_W   = 7;
  localparam int PC_W    = 6;
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(34);

  localparam int SHORT_DIV_STEPS = MAG_W;
  localparam int LONG_DIV_STEPS  = WIDE_W;
  localparam int MUL_STEPS       = MAG_W;
  localparam int SQRT_STEPS      = SQV_W / 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd2;

  localparam logic [16:0] DIG_RESET = 17'd8192;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic        [24:0] sample_count;
    logic signed [15:0] min_sample;
    logic signed [15:0] max_sample;
    logic signed [31:0] mean_q16;
    logic        [45:0] variance_q16;
    logic        [30:0] std_dev_q16;
    logic signed [47:0] min_pa_q16;
    logic signed [47:0] max_pa_q16;
    logic signed [47:0] mean_pa_q16;
    logic        [47:0] variance_pa_q16;
    logic        [31:0] std_dev_pa_q16;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SAMPLE,
    OP_DIV,
    OP_MEAN,
    OP_MUL,
    OP_M2,
    OP_VAR_DIV,
    OP_VAR_END,
    OP_SQRT,
    OP_STD_END,
    OP_PA_MUL,
    OP_PROD_DIV,
    OP_PA_END,
    OP_VPA_MUL1,
    OP_VPA_MUL2,
    OP_VPA_END,
    OP_SPA_END,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SEL_MIN,
    SEL_MAX,
    SEL_MEAN
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    op_t              op;
    sel_t             sel;
    logic [REP_W-1:0] reps;
  } uop_t;

  function automatic uop_t mk(op_t o, sel_t s, int n);
    uop_t u;
    u.op   = o;
    u.sel  = s;
    u.reps = REP_W'(n);
    return u;
  endfunction

  // Microprogram: pc 0..3 runs for every sample, 4..PC_LAST closes a read.
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_DIV,      SEL_MIN,  SHORT_DIV_STEPS);
      6'd1:  u = mk(OP_MEAN,     SEL_MIN,  1);
      6'd2:  u = mk(OP_MUL,      SEL_MIN,  MUL_STEPS);
      6'd3:  u = mk(OP_M2,       SEL_MIN,  1);
      6'd4:  u = mk(OP_VAR_DIV,  SEL_MIN,  1);
      6'd5:  u = mk(OP_DIV,      SEL_MIN,  LONG_DIV_STEPS);
      6'd6:  u = mk(OP_VAR_END,  SEL_MIN,  1);
      6'd7:  u = mk(OP_SQRT,     SEL_MIN,  SQRT_STEPS);
      6'd8:  u = mk(OP_STD_END,  SEL_MIN,  1);
      6'd9:  u = mk(OP_PA_MUL,   SEL_MIN,  1);
      6'd10: u = mk(OP_MUL,      SEL_MIN,  MUL_STEPS);
      6'd11: u = mk(OP_PROD_DIV, SEL_MIN,  1);
      6'd12: u = mk(OP_DIV,      SEL_MIN,  LONG_DIV_STEPS);
      6'd13: u = mk(OP_PA_END,   SEL_MIN,  1);
      6'd14: u = mk(OP_PA_MUL,   SEL_MAX,  1);
      6'd15: u = mk(OP_MUL,      SEL_MAX,  MUL_STEPS);
      6'd16: u = mk(OP_PROD_DIV, SEL_MAX,  1);
      6'd17: u = mk(OP_DIV,      SEL_MAX,  LONG_DIV_STEPS);
      6'd18: u = mk(OP_PA_END,   SEL_MAX,  1);
      6'd19: u = mk(OP_PA_MUL,   SEL_MEAN, 1);
      6'd20: u = mk(OP_MUL,      SEL_MEAN, MUL_STEPS);
      6'd21: u = mk(OP_PROD_DIV, SEL_MEAN, 1);
      6'd22: u = mk(OP_DIV,      SEL_MEAN, LONG_DIV_STEPS);
      6'd23: u = mk(OP_PA_END,   SEL_MEAN, 1);
      6'd24: u = mk(OP_VPA_MUL1, SEL_MIN,  1);
      6'd25: u = mk(OP_MUL,      SEL_MIN,  MUL_STEPS);
      6'd26: u = mk(OP_PROD_DIV, SEL_MIN,  1);
      6'd27: u = mk(OP_DIV,      SEL_MIN,  LONG_DIV_STEPS);
      6'd28: u = mk(OP_VPA_MUL2, SEL_MIN,  1);
      6'd29: u = mk(OP_MUL,      SEL_MIN,  MUL_STEPS);
      6'd30: u = mk(OP_PROD_DIV, SEL_MIN,  1);
      6'd31: u = mk(OP_DIV,      SEL_MIN,  LONG_DIV_STEPS);
      6'd32: u = mk(OP_VPA_END,  SEL_MIN,  1);
      6'd33: u = mk(OP_SQRT,     SEL_MIN,  SQRT_STEPS);
      6'd34: u = mk(OP_SPA_END,  SEL_MIN,  1);
      default: u = mk(OP_NOP,    SEL_MIN,  1);
    endcase
    return u;
  endfunction

endpackage

/* sv/srs_ctrl.sv */
module srs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output srs_pkg::cmd_t cmd
);
  import srs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [PC_W-1:0]  pc, pc_next;
  logic [REP_W-1:0] rep, rep_next;
  logic             last_r, last_r_next;
  logic             out_valid_next;
  uop_t             u, u_nxt, u_first;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    u              = ucode(pc);
    u_nxt          = ucode(pc + PC_W'(1));
    u_first        = ucode(PC_W'(0));
    cmd.op         = OP_NOP;
    cmd.sel        = SEL_MIN;
    state_next     = state;
    pc_next        = pc;
    rep_next       = rep;
    last_r_next    = last_r;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op      = OP_SAMPLE;
          state_next  = ST_RUN;
          pc_next     = '0;
          rep_next    = u_first.reps - REP_W'(1);
          last_r_next = in_last;
        end
      end
      ST_RUN: begin
        cmd.op  = u.op;
        cmd.sel = u.sel;
        if (rep == '0) begin
          if (u.op == OP_M2 && !last_r) begin
            state_next = ST_IDLE;
          end else if (pc == PC_LAST) begin
            state_next = ST_EMIT;
          end else begin
            pc_next  = pc + PC_W'(1);
            rep_next = u_nxt.reps - REP_W'(1);
          end
        end else begin
          rep_next = rep - REP_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      rep       <= '0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      rep       <= rep_next;
      last_r    <= last_r_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* sv/srs_datapath.sv */
module srs_datapath #(
  parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = srs_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srs_pkg::cmd_t                    cmd,
  input  srs_pkg::in_t                     in_data,
  input  logic                             cfg_valid,
  input  logic [srs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  output srs_pkg::out_t                    out_data
);
  import srs_pkg::*;

  localparam int CNT_W = COUNT_WIDTH + 1;

  // configuration
  logic signed [15:0] sample_offset;
  logic [16:0]        digitisation;
  logic [31:0]        range_pa_q16;

  // running statistics
  logic [CNT_W-1:0]   cnt;
  logic signed [15:0] rmin, rmax;
  logic signed [31:0] mean;
  logic [63:0]        m2;

  // per-sample scratch
  logic signed [32:0]  xq;
  logic                dneg;
  logic [MAG_W-1:0]    dmag;
  logic                m2_en;

  // shared units
  logic [WIDE_W-1:0]   mul_a, prod, div_q;
  logic [MAG_W-1:0]    mul_b;
  logic [REM_W-1:0]    div_rem, divisor;
  logic [SQV_W-1:0]    sq_v;
  logic [SQR_W-1:0]    sq_rem;
  logic [ROOT_W-1:0]   sq_root;

  // finish results
  logic                pa_neg;
  logic [45:0]         var_r;
  logic [30:0]         std_r;
  logic signed [47:0]  min_pa, max_pa, mean_pa;
  logic [47:0]         var_pa;

  // combinational terms
  logic [CNT_W-1:0]    cnt_next;
  logic signed [32:0]  xq_new;
  logic signed [33:0]  delta;
  logic [MAG_W-1:0]    delta_mag;
  logic [REM_W:0]      div_sh;
  logic                div_ge;
  logic [REM_W-1:0]    div_rem_new;
  logic signed [34:0]  nm;
  logic signed [31:0]  mean_new;
  logic signed [33:0]  d2;
  logic [MAG_W-1:0]    d2_mag;
  logic [WIDE_W-1:0]   p;
  logic [64:0]         m2_sum;
  logic [SQR_W+1:0]    sq_sh, sq_trial;
  logic                sq_ge;
  logic [SQR_W+1:0]    sq_diff;
  logic [45:0]         var_sat;
  logic [47:0]         vpa_sat;
  logic signed [16:0]  off17, min17, max17;
  logic signed [33:0]  pa_in;
  logic [MAG_W-1:0]    pa_mag;
  logic [47:0]         pa_cap, pa_r, pa_res;
  logic [16:0]         dig_eff;

  always_comb begin
    cnt_next  = cnt[COUNT_WIDTH] ? cnt : cnt + CNT_W'(1);
    xq_new    = $signed({{17{in_data.sample[15]}}, in_data.sample}) <<< FRAC_BITS;
    delta     = {xq_new[32], xq_new} - {{2{mean[31]}}, mean};
    delta_mag = delta[33] ? MAG_W'(-delta) : MAG_W'(delta);

    // restoring divider step
    div_sh      = {div_rem, div_q[WIDE_W-1]};
    div_ge      = div_sh >= {1'b0, divisor};
    div_rem_new = div_ge ? REM_W'(div_sh - {1'b0, divisor}) : REM_W'(div_sh);

    // mean update from the quotient
    nm = dneg ? ({{3{mean[31]}}, mean} - {1'b0, div_q[MAG_W-1:0]})
              : ({{3{mean[31]}}, mean} + {1'b0, div_q[MAG_W-1:0]});
    if (nm > 35'sh0_7FFF_FFFF)       mean_new = 32'sh7FFF_FFFF;
    else if (nm < -35'sh0_8000_0000) mean_new = 32'sh8000_0000;
    else                             mean_new = nm[31:0];
    d2     = {xq[32], xq} - {{2{mean_new[31]}}, mean_new};
    d2_mag = d2[33] ? MAG_W'(-d2) : MAG_W'(d2);

    p      = prod >> FRAC_BITS;
    m2_sum = {1'b0, m2} + {1'b0, p[63:0]};

    // digit-by-digit square root step
    sq_sh    = {sq_rem, sq_v[SQV_W-1 -: 2]};
    sq_trial = {2'b00, sq_root, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_ge ? sq_sh - sq_trial : sq_sh;

    var_sat = (div_q > WIDE_W'(46'h3FFF_FFFF_FFFF)) ? 46'h3FFF_FFFF_FFFF : div_q[45:0];
    vpa_sat = (div_q[WIDE_W-1:32] > 80'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF
                                                             : div_q[79:32];

    off17 = {sample_offset[15], sample_offset};
    min17 = {rmin[15], rmin} + off17;
    max17 = {rmax[15], rmax} + off17;
    case (cmd.sel)
      SEL_MIN:  pa_in = $signed({{17{min17[16]}}, min17}) <<< FRAC_BITS;
      SEL_MAX:  pa_in = $signed({{17{max17[16]}}, max17}) <<< FRAC_BITS;
      SEL_MEAN: pa_in = {{2{mean[31]}}, mean}
                        + ($signed({{18{sample_offset[15]}}, sample_offset}) <<< FRAC_BITS);
      default:  pa_in = '0;
    endcase
    pa_mag = pa_in[33] ? MAG_W'(-pa_in) : MAG_W'(pa_in);

    pa_cap = pa_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    pa_r   = (div_q[WIDE_W-1:16] > 96'(pa_cap)) ? pa_cap : div_q[63:16];
    pa_res = pa_neg ? -pa_r : pa_r;

    dig_eff = (digitisation == '0) ? 17'd1 : digitisation;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset <= '0;
      digitisation  <= DIG_RESET;
      range_pa_q16  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET: sample_offset <= cfg_data[15:0];
        CFG_DIG:    digitisation  <= cfg_data[16:0];
        CFG_RANGE:  range_pa_q16  <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      rmin <= SAMPLE_MAX;
      rmax <= SAMPLE_MIN;
      mean <= '0;
      m2   <= '0;
    end else begin
      case (cmd.op)
        OP_SAMPLE: begin
          cnt <= cnt_next;
          if (in_data.sample < rmin) rmin <= in_data.sample;
          if (in_data.sample > rmax) rmax <= in_data.sample;
        end
        OP_MEAN: mean <= mean_new;
        OP_M2: begin
          if (m2_en) begin
            m2 <= ((|p[WIDE_W-1:64]) || m2_sum[64]) ? '1 : m2_sum[63:0];
          end
        end
        OP_EMIT: begin
          cnt  <= '0;
          rmin <= SAMPLE_MAX;
          rmax <= SAMPLE_MIN;
          mean <= '0;
          m2   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SAMPLE: begin
        xq      <= xq_new;
        dneg    <= delta[33];
        dmag    <= delta_mag;
        div_q   <= {delta_mag, {(WIDE_W-MAG_W){1'b0}}};
        div_rem <= '0;
        divisor <= REM_W'(cnt_next);
      end
      OP_DIV: begin
        div_q   <= {div_q[WIDE_W-2:0], div_ge};
        div_rem <= div_rem_new;
      end
      OP_MEAN: begin
        mul_a <= WIDE_W'(dmag);
        mul_b <= d2_mag;
        prod  <= '0;
        m2_en <= (dmag == '0) || (d2 == '0) || (dneg == d2[33]);
      end
      OP_MUL: begin
        if (mul_b[0]) prod <= prod + mul_a;
        mul_a <= {mul_a[WIDE_W-2:0], 1'b0};
        mul_b <= {1'b0, mul_b[MAG_W-1:1]};
      end
      OP_VAR_DIV: begin
        div_q   <= WIDE_W'(m2);
        div_rem <= '0;
        divisor <= REM_W'(cnt);
      end
      OP_VAR_END: begin
        var_r   <= var_sat;
        sq_v    <= SQV_W'(var_sat) << FRAC_BITS;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_SQRT: begin
        sq_v    <= {sq_v[SQV_W-3:0], 2'b00};
        sq_rem  <= sq_diff[SQR_W-1:0];
        sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
      end
      OP_STD_END: std_r <= sq_root[30:0];
      OP_PA_MUL: begin
        pa_neg <= pa_in[33];
        mul_a  <= WIDE_W'(pa_mag);
        mul_b  <= MAG_W'(range_pa_q16);
        prod   <= '0;
      end
      OP_PROD_DIV: begin
        div_q   <= prod;
        div_rem <= '0;
        divisor <= REM_W'(dig_eff);
      end
      OP_PA_END: begin
        case (cmd.sel)
          SEL_MIN:  min_pa  <= pa_res;
          SEL_MAX:  max_pa  <= pa_res;
          SEL_MEAN: mean_pa <= pa_res;
          default:  ;
        endcase
      end
      OP_VPA_MUL1: begin
        mul_a <= WIDE_W'(var_r);
        mul_b <= MAG_W'(range_pa_q16);
        prod  <= '0;
      end
      OP_VPA_MUL2: begin
        mul_a <= div_q;
        mul_b <= MAG_W'(range_pa_q16);
        prod  <= '0;
      end
      OP_VPA_END: begin
        var_pa  <= vpa_sat;
        sq_v    <= SQV_W'(vpa_sat) << FRAC_BITS;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_EMIT: begin
        out_data.sample_count    <= 25'(cnt);
        out_data.min_sample      <= rmin;
        out_data.max_sample      <= rmax;
        out_data.mean_q16        <= mean;
        out_data.variance_q16    <= var_r;
        out_data.std_dev_q16     <= std_r;
        out_data.min_pa_q16      <= min_pa;
        out_data.max_pa_q16      <= max_pa;
        out_data.mean_pa_q16     <= mean_pa;
        out_data.variance_pa_q16 <= var_pa;
        out_data.std_dev_pa_q16  <= sq_root;
      end
      default: ;
    endcase
  end

endmodule

/* sv/sample_running_statistics.sv */
// Running statistics over the raw samples of one read. Each accepted sample updates
// a saturating count, min, max, a Welford running mean and the sum of squared
// deviations. A sample flagged last is folded in first; then one result transaction
// carries count, min, max, mean, population variance, standard deviation and the
// picoamp forms of min, max, mean, variance and std dev, after which the statistics
// clear. Each sample occupies the block through accept, 34 steps of the restoring
// divider for delta/n, mean update, 34 steps of the shift-add multiplier and
// accumulate, and in_stall holds off the next sample until then. A last sample adds
// a read close-out dominated by six 112-step passes through the same divider and two
// 32-step square roots; samples of the next read are accepted while a finished result
// is still waiting on out_stall. Configuration writes are always ready and take effect
// at once; write them only while no read is in flight.
module sample_running_statistics #(
  parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = srs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srs_pkg::in_t                  in_data,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_stall,
  output srs_pkg::out_t                 out_data,
  // register writes: 0 offset, 1 digitisation, 2 range; others dropped
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import srs_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer: walks the microprogram, owns both handshakes
  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // statistics registers, shared divider / multiplier / sqrt, result register
  srs_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* bench/tb_sample_running_statistics.sv */
`timescale 1ns / 1ps

module tb_sample_running_statistics;
  import srs_pkg::*;

  localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 6000000;
  // settle time after the last result: long enough for a bare sample's work to finish
  localparam int SETTLE_CYCLES = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #10 clk = ~clk;

  sample_running_statistics u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: register file and per-read statistics
  // ---------------------------------------------------------------------------
  logic signed [15:0] shadow_offset;
  logic [16:0]        shadow_dig;
  logic [31:0]        shadow_range;

  logic [24:0]        acc_count;
  logic signed [15:0] acc_min;
  logic signed [15:0] acc_max;
  logic signed [31:0] acc_mean;
  logic [63:0]        acc_m2;

  out_t pending_stats[$];   // read summaries still owed by the block
  int   mismatches = 0;
  int   stray_results = 0;
  int   sent_items = 0;

  function automatic void clear_read();
    acc_count = '0;
    acc_min   = SAMPLE_MAX;
    acc_max   = SAMPLE_MIN;
    acc_mean  = '0;
    acc_m2    = '0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [127:0] dig_eff();
    return (shadow_dig == 0) ? 128'd1 : 128'(shadow_dig);
  endfunction

  // signed Q.F value to picoamps Q.F: magnitude*range/dig, truncate toward zero
  function automatic logic [47:0] scale_to_pa(logic signed [63:0] vq);
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] shifted;
    logic [127:0] cap;
    neg  = vq < 0;
    mag  = neg ? 64'(-vq) : 64'(vq);
    prod = 128'(mag) * 128'(shadow_range);
    prod = prod / dig_eff();
    shifted = prod >> 16;
    cap = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (shifted > cap) shifted = cap;
    return neg ? 48'(-shifted) : 48'(shifted);
  endfunction

  // Welford update for one accepted sample; queues a summary on the last one
  function automatic void fold_sample(in_t it);
    logic signed [63:0] xq, delta, d2, nm, base, offq;
    logic [63:0]        mag, quo, mag2, part, vr, vpa;
    logic [127:0]       wide;
    out_t               sum;
    if (acc_count < (25'd1 << COUNT_WIDTH)) acc_count = acc_count + 1;
    if (it.sample < acc_min) acc_min = it.sample;
    if (it.sample > acc_max) acc_max = it.sample;

    xq    = 64'(it.sample) * 64'sd65536;
    base  = 64'(acc_mean);
    delta = xq - base;
    mag   = (delta < 0) ? 64'(-delta) : 64'(delta);
    quo   = mag / 64'(acc_count);
    nm    = (delta < 0) ? base - $signed(quo) : base + $signed(quo);
    if (nm > 64'sh7FFF_FFFF) nm = 64'sh7FFF_FFFF;
    if (nm < -64'sh8000_0000) nm = -64'sh8000_0000;
    acc_mean = 32'(nm);

    d2 = xq - nm;
    if ((delta >= 0 && d2 >= 0) || (delta <= 0 && d2 <= 0)) begin
      mag2 = (d2 < 0) ? 64'(-d2) : 64'(d2);
      part = (mag * mag2) >> FRAC_BITS;   // wraps at 64 bits, where the block saturates
      if (acc_m2 > ~64'd0 - part) acc_m2 = ~64'd0;
      else acc_m2 = acc_m2 + part;
    end

    if (!it.last) return;

    vr = acc_m2 / 64'(acc_count);
    if (vr > (64'd1 << 46) - 1) vr = (64'd1 << 46) - 1;
    wide = 128'(vr) * 128'(shadow_range) / dig_eff();
    wide = wide * 128'(shadow_range) / dig_eff();
    wide = wide >> 32;
    vpa  = (wide > 128'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : 64'(wide);

    offq = 64'(shadow_offset) * 64'sd65536;
    sum.sample_count    = acc_count;
    sum.min_sample      = acc_min;
    sum.max_sample      = acc_max;
    sum.mean_q16        = acc_mean;
    sum.variance_q16    = 46'(vr);
    sum.std_dev_q16     = 31'(int_sqrt(vr << FRAC_BITS));
    sum.min_pa_q16      = scale_to_pa((64'(acc_min) + 64'(shadow_offset)) * 64'sd65536);
    sum.max_pa_q16      = scale_to_pa((64'(acc_max) + 64'(shadow_offset)) * 64'sd65536);
    sum.mean_pa_q16     = scale_to_pa(64'(acc_mean) + offq);
    sum.variance_pa_q16 = 48'(vpa);
    sum.std_dev_pa_q16  = 32'(int_sqrt(vpa << FRAC_BITS));
    pending_stats.push_back(sum);
    clear_read();
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // offer one sample transaction, wait for acceptance, then idle for gap cycles
  task automatic push_sample(logic signed [15:0] s, logic lst, int gap);
    in_t it;
    it.sample = s;
    it.last   = lst;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_sample(it);
    sent_items++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one register write transaction, then cfg_valid drops before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OFFSET: shadow_offset = val[15:0];
      CFG_DIG:    shadow_dig    = val[16:0];
      CFG_RANGE:  shadow_range  = val;
      default: ;  // index out of the map: dropped
    endcase
    @(posedge clk);
  endtask

  // block idle: nothing owed and any trailing sample work finished
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scaling(logic [31:0] off, logic [31:0] dig, logic [31:0] rng);
    wait_idle();
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_DIG, dig);
    write_reg(CFG_RANGE, rng);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver backpressure: random runs of stall / no stall, plus a long hold
  // ---------------------------------------------------------------------------
  int hold_len = 0;
  int hold_req = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int stall_run = 0;
  logic stall_mode = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left  = hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_mode = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(200, 2000);
        else stall_run = $urandom_range(1, 8);
        if (stall_mode && stall_run > 400) stall_run = 400;
      end
      stall_run--;
      out_stall <= stall_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(string nm, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h", nm, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        stray_results++;
        $display("result transaction with nothing outstanding");
      end else begin
        want = pending_stats.pop_front();
        check_field("sample_count", 64'(want.sample_count), 64'(out_data.sample_count));
        check_field("min_sample", 64'(want.min_sample), 64'(out_data.min_sample));
        check_field("max_sample", 64'(want.max_sample), 64'(out_data.max_sample));
        check_field("mean_q16", 64'(want.mean_q16), 64'(out_data.mean_q16));
        check_field("variance_q16", 64'(want.variance_q16), 64'(out_data.variance_q16));
        check_field("std_dev_q16", 64'(want.std_dev_q16), 64'(out_data.std_dev_q16));
        check_field("min_pa_q16", 64'(want.min_pa_q16), 64'(out_data.min_pa_q16));
        check_field("max_pa_q16", 64'(want.max_pa_q16), 64'(out_data.max_pa_q16));
        check_field("mean_pa_q16", 64'(want.mean_pa_q16), 64'(out_data.mean_pa_q16));
        check_field("variance_pa_q16", 64'(want.variance_pa_q16),
                    64'(out_data.variance_pa_q16));
        check_field("std_dev_pa_q16", 64'(want.std_dev_pa_q16),
                    64'(out_data.std_dev_pa_q16));
      end
    end
  end

  // watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // sample drawn per read: extremes, a tight cluster, or anything
  function automatic logic signed [15:0] pick_sample(logic signed [15:0] center);
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return 16'($urandom_range(0, 65535));
      default: return center + 16'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic send_read(int len, logic quick);
    logic signed [15:0] center;
    center = 16'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++)
      push_sample(pick_sample(center), i == len - 1, quick ? 0 : pick_gap());
  endtask

  // reset values of the registers; range 0 makes every picoamp field zero
  task automatic test_reset_scaling();
    push_sample(16'sd5, 1'b1, 0);
    push_sample(-16'sd3, 1'b0, 2);
    push_sample(16'sd9, 1'b1, 0);
  endtask

  // sample extremes, single-sample reads, a wide-swing read and an all-zero read
  task automatic test_sample_extremes();
    set_scaling(32'd0, 32'd8192, 32'h0064_0000);
    push_sample(SAMPLE_MAX, 1'b1, 0);
    push_sample(SAMPLE_MIN, 1'b1, 1);
    for (int i = 0; i < 6; i++)
      push_sample((i % 2) ? SAMPLE_MIN : SAMPLE_MAX, i == 5, 0);
    push_sample(16'sd0, 1'b0, 0);
    push_sample(16'sd0, 1'b0, 0);
    push_sample(16'sd0, 1'b1, 0);
  endtask

  // zero digitisation acts as one, full-scale range saturates the picoamp fields,
  // offset extremes, and a write outside the register map changes nothing
  task automatic test_scaling_extremes();
    set_scaling(32'h0000_7FFF, 32'd0, 32'hFFFF_FFFF);
    push_sample(SAMPLE_MAX, 1'b0, 0);
    push_sample(SAMPLE_MIN, 1'b1, 0);
    set_scaling(32'hFFFF_8000, 32'h0001_0000, 32'hFFFF_FFFF);
    push_sample(SAMPLE_MIN, 1'b0, 0);
    push_sample(16'sd100, 1'b1, 0);
    set_scaling(32'h0000_0000, 32'd1, 32'h0001_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    push_sample(SAMPLE_MAX, 1'b0, 0);
    push_sample(-16'sd1, 1'b1, 0);
  endtask

  // random reads; scaling changes now and then, extremes among the choices
  task automatic test_random_reads();
    int reads;
    logic [31:0] dv;
    reads = 0;
    while (sent_items < 830) begin
      if (reads % 12 == 0) begin
        case ($urandom_range(0, 3))
          0: dv = 32'd0;
          1: dv = 32'd1;
          2: dv = 32'h0001_0000;
          default: dv = $urandom();
        endcase
        set_scaling($urandom(), dv, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom());
      end
      if ($urandom_range(0, 19) == 0) send_read($urandom_range(20, 40), 1'b0);
      else send_read($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      reads++;
    end
  endtask

  // receiver holds off for a long stretch while short reads keep coming
  task automatic test_result_backpressure();
    wait_idle();
    hold_len = 5000;
    hold_req++;
    for (int r = 0; r < 6; r++) send_read(2, 1'b1);
  endtask

  initial begin
    clear_read();
    shadow_offset = '0;
    shadow_dig    = DIG_RESET;
    shadow_range  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_scaling();
    test_sample_extremes();
    test_scaling_extremes();
    test_random_reads();
    test_result_backpressure();

    wait_idle();
    if (mismatches == 0 && stray_results == 0 && pending_stats.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sample_running_statistics.f */
sv/srs_pkg.sv
sv/srs_ctrl.sv
sv/srs_datapath.sv
sv/sample_running_statistics.sv
bench/tb_sample_running_statistics.sv
